>>> design/pbf_pkg.sv
// pbf_pkg: shared types and codes for the byte pipe.
// Holds operation and status codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package pbf_pkg;

    localparam int FUNC_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 9;
    localparam int IN_W     = 16;   // func + data_in, padded to bytes
    localparam int OUT_W    = 24;   // data_out + status + is_open + fill_level, padded

    typedef enum logic [FUNC_W-1:0] {
        FN_OPEN      = 3'd0,
        FN_WRITE     = 3'd1,
        FN_READ      = 3'd2,
        FN_CLOSE_RD  = 3'd3,
        FN_CLOSE_WR  = 3'd4,
        FN_ADD_RD    = 3'd5,
        FN_ADD_WR    = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_FULL   = 3'd2,
        ST_CLOSED = 3'd3,
        ST_NOREAD = 3'd4,
        ST_ZERO   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic take;   // latch the incoming request
        logic exec;   // perform the operation on pipe state
        logic load;   // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> design/pbf_ctrl.sv
// pbf_ctrl: request sequencer for the byte pipe.
// Drives take/exec/load commands into pbf_datapath; uses pbf_pkg types.
`default_nettype none

module pbf_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pbf_pkg::sts_t sts,
    output pbf_pkg::cmd_t      cmd
);

    pbf_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbf_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pbf_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = pbf_pkg::S_EXEC;
                end
            end
            pbf_pkg::S_EXEC: begin
                state_next = pbf_pkg::S_LOAD;
            end
            pbf_pkg::S_LOAD: begin
                if (sts.out_free) begin
                    state_next = pbf_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pbf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            pbf_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            pbf_pkg::S_EXEC: begin
                cmd.exec = 1'b1;
            end
            pbf_pkg::S_LOAD: begin
                cmd.load = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/pbf_datapath.sv
// pbf_datapath: byte store, pointers, end counts, open flag and result register.
// Acts on commands from pbf_ctrl; uses pbf_pkg codes and structs.
`default_nettype none

module pbf_datapath #(
    parameter int PIPE_DEPTH = 512,
    parameter int COUNT_MAX  = 255
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pbf_pkg::cmd_t                 cmd,
    output pbf_pkg::sts_t                      sts,
    input  wire logic [pbf_pkg::FUNC_W-1:0]    func_in,
    input  wire logic [pbf_pkg::BYTE_W-1:0]    data_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [pbf_pkg::BYTE_W-1:0]         data_out,
    output logic [pbf_pkg::STATUS_W-1:0]       status,
    output logic                               is_open,
    output logic [pbf_pkg::FILL_W-1:0]         fill_level
);

    localparam int PTR_W = $clog2(PIPE_DEPTH);
    localparam int LVL_W = PTR_W + 1;
    localparam int CNT_W = $clog2(COUNT_MAX + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(PIPE_DEPTH - 1);
    localparam logic [LVL_W-1:0] DEPTH_LVL = LVL_W'(PIPE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(COUNT_MAX);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    logic [pbf_pkg::BYTE_W-1:0] store [PIPE_DEPTH];

    pbf_pkg::func_t               func_reg;
    logic [pbf_pkg::BYTE_W-1:0]   din_reg;
    logic [PTR_W-1:0]             rp_reg, rp_next;
    logic [PTR_W-1:0]             wp_reg, wp_next;
    logic [CNT_W-1:0]             rcnt_reg, rcnt_next;
    logic [CNT_W-1:0]             wcnt_reg, wcnt_next;
    logic                         open_reg, open_next;
    pbf_pkg::status_t             st_reg, st_next;
    logic                         rd_ok_reg, rd_ok_next;
    logic                         mem_we;
    logic [pbf_pkg::BYTE_W-1:0]   rdata_reg;

    logic                         mvalid_reg;
    logic [pbf_pkg::BYTE_W-1:0]   dout_reg;
    pbf_pkg::status_t             ost_reg;
    logic                         oopen_reg;
    logic [pbf_pkg::FILL_W-1:0]   fill_reg;

    logic [PTR_W-1:0]             wp_adv, rp_adv;
    logic [LVL_W-1:0]             level;

    assign wp_adv = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
    assign rp_adv = (rp_reg == PTR_LAST) ? '0 : rp_reg + PTR_W'(1);

    // wrapped distance; depth need not be a power of two
    assign level = (wp_reg >= rp_reg) ? ({1'b0, wp_reg} - {1'b0, rp_reg})
                                      : (DEPTH_LVL - {1'b0, rp_reg} + {1'b0, wp_reg});

    always_comb begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        rcnt_next  = rcnt_reg;
        wcnt_next  = wcnt_reg;
        open_next  = open_reg;
        st_next    = pbf_pkg::ST_OK;
        rd_ok_next = 1'b0;
        mem_we     = 1'b0;
        unique case (func_reg)
            pbf_pkg::FN_OPEN: begin
                rp_next   = '0;
                wp_next   = '0;
                rcnt_next = CNT_ONE;
                wcnt_next = CNT_ONE;
                open_next = 1'b1;
            end
            pbf_pkg::FN_WRITE: begin
                priority if (!open_reg) begin
                    st_next = pbf_pkg::ST_CLOSED;
                end else if (rcnt_reg == '0) begin
                    st_next = pbf_pkg::ST_NOREAD;
                end else if (wp_adv == rp_reg) begin
                    st_next = pbf_pkg::ST_FULL;
                end else begin
                    mem_we  = 1'b1;
                    wp_next = wp_adv;
                end
            end
            pbf_pkg::FN_READ: begin
                priority if (!open_reg) begin
                    st_next = pbf_pkg::ST_CLOSED;
                end else if (rp_reg == wp_reg) begin
                    st_next = pbf_pkg::ST_EMPTY;
                end else begin
                    rd_ok_next = 1'b1;
                    rp_next    = rp_adv;
                end
            end
            pbf_pkg::FN_CLOSE_RD: begin
                if (rcnt_reg == '0) begin
                    st_next = pbf_pkg::ST_ZERO;
                end else begin
                    rcnt_next = rcnt_reg - CNT_ONE;
                end
                if (rcnt_next == '0 && wcnt_reg == '0) begin
                    open_next = 1'b0;
                end
            end
            pbf_pkg::FN_CLOSE_WR: begin
                if (wcnt_reg == '0) begin
                    st_next = pbf_pkg::ST_ZERO;
                end else begin
                    wcnt_next = wcnt_reg - CNT_ONE;
                end
                if (rcnt_reg == '0 && wcnt_next == '0) begin
                    open_next = 1'b0;
                end
            end
            pbf_pkg::FN_ADD_RD: begin
                if (rcnt_reg < CNT_MAX) begin
                    rcnt_next = rcnt_reg + CNT_ONE;
                end
            end
            pbf_pkg::FN_ADD_WR: begin
                if (wcnt_reg < CNT_MAX) begin
                    wcnt_next = wcnt_reg + CNT_ONE;
                end
            end
            default: begin
                st_next = pbf_pkg::ST_OK;   // unused code: no-op
            end
        endcase
    end

    // byte store: one write port, one registered read port, both at the pointers
    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            store[wp_reg] <= din_reg;
        end
        if (cmd.exec) begin
            rdata_reg <= store[rp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            func_reg <= pbf_pkg::func_t'(func_in);
            din_reg  <= data_in;
        end
        if (cmd.exec) begin
            st_reg    <= st_next;
            rd_ok_reg <= rd_ok_next;
        end
        if (cmd.load) begin
            dout_reg  <= rd_ok_reg ? rdata_reg : '0;
            ost_reg   <= st_reg;
            oopen_reg <= open_reg;
            fill_reg  <= pbf_pkg::FILL_W'(level);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg     <= '0;
            wp_reg     <= '0;
            rcnt_reg   <= '0;
            wcnt_reg   <= '0;
            open_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                rp_reg   <= rp_next;
                wp_reg   <= wp_next;
                rcnt_reg <= rcnt_next;
                wcnt_reg <= wcnt_next;
                open_reg <= open_next;
            end
            if (cmd.load) begin
                mvalid_reg <= 1'b1;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free = !mvalid_reg || m_ready;
    assign m_valid      = mvalid_reg;
    assign data_out     = dout_reg;
    assign status       = ost_reg;
    assign is_open      = oopen_reg;
    assign fill_level   = fill_reg;

endmodule

`default_nettype wire

>>> design/pipe_byte_fifo_with_endpoints.sv
// Byte pipe top level: stream ports around pbf_ctrl and pbf_datapath.
// Depends on pbf_pkg, pbf_ctrl, pbf_datapath.
//
// Each request on the s_axis side is one operation on a circular byte FIFO of
// PIPE_DEPTH slots (one slot always kept empty) plus reader/writer end counts
// and an open flag; each produces exactly one result on m_axis. A request passes
// through capture, execute (state update plus a registered read of the
// single-port-per-side byte memory), and transfer to the output register, which
// waits while the sink stalls the previous result. A new request is taken as soon
// as the previous result sits in the output register, so requests are handled one
// at a time. fill_level reports the low nine bits of the held byte count.
// Reset needs no clearing pass; stored bytes are only read after being written.
`default_nettype none

module pipe_byte_fifo_with_endpoints #(
    parameter int PIPE_DEPTH = 512,
    parameter int COUNT_MAX  = 255
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] func, [10:3] data_in, [15:11] zero
    input  wire logic [pbf_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [7:0] data_out, [10:8] status, [11] is_open, [20:12] fill_level, [23:21] zero
    output logic [pbf_pkg::OUT_W-1:0]        m_axis_tdata
);

    pbf_pkg::cmd_t                 cmd;
    pbf_pkg::sts_t                 sts;
    logic [pbf_pkg::BYTE_W-1:0]    data_out;
    logic [pbf_pkg::STATUS_W-1:0]  status;
    logic                          is_open;
    logic [pbf_pkg::FILL_W-1:0]    fill_level;

    pbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pbf_datapath #(
        .PIPE_DEPTH (PIPE_DEPTH),
        .COUNT_MAX  (COUNT_MAX)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .func_in    (s_axis_tdata[2:0]),
        .data_in    (s_axis_tdata[10:3]),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .data_out   (data_out),
        .status     (status),
        .is_open    (is_open),
        .fill_level (fill_level)
    );

    assign m_axis_tdata = {3'b000, fill_level, is_open, status, data_out};

endmodule

`default_nettype wire

>>> design/pbf_checker.sv
// pbf_checker: port-level assertions for the byte pipe, bound to the top level.
// Depends on pbf_pkg and pipe_byte_fifo_with_endpoints.
`default_nettype none

module pbf_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [pbf_pkg::OUT_W-1:0]   m_axis_tdata
);

    // result stalled by the sink holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one request at a time: ready drops right after an accept
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while one in flight");

    // a closed-pipe status always reports the pipe closed
    a_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[10:8] == pbf_pkg::ST_CLOSED |-> !m_axis_tdata[11])
        else $error("closed status with open flag");

    // only a successful operation carries a nonzero byte
    a_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[7:0] != 8'd0 |-> m_axis_tdata[10:8] == pbf_pkg::ST_OK)
        else $error("data byte with failing status");

    // reset empties the output register
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind pipe_byte_fifo_with_endpoints pbf_checker u_pbf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
